/* sv/append_only_record_page_core_macros.svh */
// Assertion helpers used by the record page controller.
`ifndef APPEND_ONLY_RECORD_PAGE_CORE_MACROS_SVH
`define APPEND_ONLY_RECORD_PAGE_CORE_MACROS_SVH

`ifndef SYNTH
// Invariant checked at every clock edge outside reset.
`define AORP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("aorp assertion failed");
// Same-cycle implication.
`define AORP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("aorp assertion failed");
// Next-cycle implication.
`define AORP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("aorp assertion failed");
`else
`define AORP_ASSERT(lbl, clk, rst_n, prop)
`define AORP_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define AORP_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* sv/aorp_pkg.sv */
`timescale 1ns / 1ps

package aorp_pkg;

  // Default number of records in the page.
  localparam int CAPACITY_DEF = 128;

  // Field widths.
  localparam int KEY_BITS  = 40;
  localparam int KEY_IN_W  = 64;
  localparam int FLAG_W    = 8;
  localparam int POS_W     = 7;
  localparam int IDX_W     = 16;
  localparam int KF_W      = KEY_BITS + FLAG_W;
  localparam int HINT_W    = 64;
  localparam int PAY_W     = 64;
  localparam int GRP_W     = 32;

  typedef enum logic [1:0] {
    OP_APPEND    = 2'd0,
    OP_READ      = 2'd1,
    OP_WRITE     = 2'd2,
    OP_SET_FLAGS = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_RANGE    = 2'd2,
    ST_BAD_ARG  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_READ   = 2'd1,
    S_MODIFY = 2'd2
  } state_t;

  // Input request.
  typedef struct packed {
    op_t                opcode;
    logic [15:0]        index;
    logic [63:0]        key;
    logic [7:0]         flag_bits;
    logic [31:0]        page_number;
    logic [15:0]        epoch;
    logic [15:0]        slot_hint;
    logic signed [63:0] payload;
    logic [31:0]        group;
    logic [7:0]         set_mask;
    logic [7:0]         clear_mask;
  } in_req_t;

  // Result.
  typedef struct packed {
    status_t            status;
    logic [6:0]         position;
    logic [39:0]        read_key;
    logic [7:0]         read_flags;
    logic [31:0]        read_page_number;
    logic [15:0]        read_epoch;
    logic [15:0]        read_slot;
    logic signed [63:0] read_payload;
    logic [31:0]        read_group;
  } out_res_t;

  // One stored record, one word of each store.
  typedef struct packed {
    logic [KF_W-1:0]   kf;
    logic [HINT_W-1:0] hint;
    logic [PAY_W-1:0]  pay;
    logic [GRP_W-1:0]  grp;
  } record_t;

  // Store port controls from the sequencer.
  typedef struct packed {
    logic rd;
    logic wr_rec;
    logic wr_kf;
  } store_ctl_t;

endpackage

/* sv/aorp_store.sv */
`timescale 1ns / 1ps

module aorp_store #(
  parameter int  CAPACITY = aorp_pkg::CAPACITY_DEF,
  localparam int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic                 clk,
  input  aorp_pkg::store_ctl_t ctl,
  input  logic [AW-1:0]        waddr,
  input  aorp_pkg::record_t    wdata,
  input  logic [AW-1:0]        raddr,
  output aorp_pkg::record_t    rdata
);

  logic [aorp_pkg::KF_W-1:0]   kf_mem   [CAPACITY];
  logic [aorp_pkg::HINT_W-1:0] hint_mem [CAPACITY];
  logic [aorp_pkg::PAY_W-1:0]  pay_mem  [CAPACITY];
  logic [aorp_pkg::GRP_W-1:0]  grp_mem  [CAPACITY];
  aorp_pkg::record_t           rdata_r;

  // A full record write touches all four stores; a flag update only the key store.
  always_ff @(posedge clk) begin
    if (ctl.wr_rec || ctl.wr_kf) begin
      kf_mem[waddr] <= wdata.kf;
    end
    if (ctl.wr_rec) begin
      hint_mem[waddr] <= wdata.hint;
      pay_mem[waddr]  <= wdata.pay;
      grp_mem[waddr]  <= wdata.grp;
    end
  end

  // Registered read, updated only while rd is high.
  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      rdata_r.kf   <= kf_mem[raddr];
      rdata_r.hint <= hint_mem[raddr];
      rdata_r.pay  <= pay_mem[raddr];
      rdata_r.grp  <= grp_mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* sv/aorp_ctrl.sv */
`timescale 1ns / 1ps
`include "append_only_record_page_core_macros.svh"

module aorp_ctrl #(
  parameter int  CAPACITY = aorp_pkg::CAPACITY_DEF,
  localparam int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  aorp_pkg::in_req_t    in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output aorp_pkg::out_res_t   out_data,
  output aorp_pkg::store_ctl_t st_ctl,
  output logic [AW-1:0]        st_waddr,
  output aorp_pkg::record_t    st_wdata,
  output logic [AW-1:0]        st_raddr,
  input  aorp_pkg::record_t    st_rdata
);

  localparam int CW = $clog2(CAPACITY + 1);

  aorp_pkg::state_t   state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic               out_valid_r, out_valid_nxt;
  aorp_pkg::out_res_t out_data_r, out_data_nxt;
  logic [AW-1:0]      addr_r, addr_nxt;
  logic [7:0]         set_r, set_nxt;
  logic [7:0]         clr_r, clr_nxt;

  logic                               accept;
  logic                               key_bad;
  logic                               full;
  logic                               idx_below_cnt;
  logic                               idx_upto_cnt;
  logic                               idx_in_cap;
  logic [aorp_pkg::IDX_W-1:0]         cnt_ext;
  aorp_pkg::status_t                  status;
  aorp_pkg::record_t                  new_rec;
  logic [7:0]                         mod_flags;

  // Handshake: one request in flight, and the result register must be free.
  assign in_stall = (state_r != aorp_pkg::S_IDLE) || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;

  // Request checks against the published count and the capacity.
  assign key_bad       = |in_data.key[aorp_pkg::KEY_IN_W-1:aorp_pkg::KEY_BITS];
  assign full          = count_r >= CW'(CAPACITY);
  assign cnt_ext       = aorp_pkg::IDX_W'(count_r);
  assign idx_below_cnt = in_data.index < cnt_ext;
  assign idx_upto_cnt  = in_data.index <= cnt_ext;
  assign idx_in_cap    = in_data.index < aorp_pkg::IDX_W'(CAPACITY);

  always_comb begin
    status = aorp_pkg::ST_OK;
    case (in_data.opcode)
      aorp_pkg::OP_APPEND: begin
        if (full) begin
          status = aorp_pkg::ST_NO_SPACE;
        end else if (key_bad) begin
          status = aorp_pkg::ST_BAD_ARG;
        end
      end
      aorp_pkg::OP_WRITE: begin
        if (!idx_upto_cnt || !idx_in_cap) begin
          status = aorp_pkg::ST_RANGE;
        end else if (key_bad) begin
          status = aorp_pkg::ST_BAD_ARG;
        end
      end
      aorp_pkg::OP_READ, aorp_pkg::OP_SET_FLAGS: begin
        if (!idx_below_cnt || !idx_in_cap) begin
          status = aorp_pkg::ST_RANGE;
        end
      end
      default: status = aorp_pkg::ST_OK;
    endcase
  end

  // Record image built from the request.
  always_comb begin
    new_rec.kf   = {in_data.flag_bits, in_data.key[aorp_pkg::KEY_BITS-1:0]};
    new_rec.hint = {in_data.slot_hint, in_data.epoch, in_data.page_number};
    new_rec.pay  = in_data.payload;
    new_rec.grp  = in_data.group;
  end

  // Flag byte of the entry read back, updated with the saved masks.
  assign mod_flags = (st_rdata.kf[aorp_pkg::KF_W-1:aorp_pkg::KEY_BITS] | set_r) & ~clr_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      aorp_pkg::S_IDLE: begin
        if (accept && status == aorp_pkg::ST_OK) begin
          if (in_data.opcode == aorp_pkg::OP_READ) begin
            state_nxt = aorp_pkg::S_READ;
          end else if (in_data.opcode == aorp_pkg::OP_SET_FLAGS) begin
            state_nxt = aorp_pkg::S_MODIFY;
          end
        end
      end
      aorp_pkg::S_READ:   state_nxt = aorp_pkg::S_IDLE;
      aorp_pkg::S_MODIFY: state_nxt = aorp_pkg::S_IDLE;
      default:            state_nxt = aorp_pkg::S_IDLE;
    endcase
  end

  // Store accesses, count and result register.
  always_comb begin
    st_ctl        = '0;
    st_waddr      = in_data.index[AW-1:0];
    st_raddr      = in_data.index[AW-1:0];
    st_wdata      = new_rec;
    count_nxt     = count_r;
    addr_nxt      = addr_r;
    set_nxt       = set_r;
    clr_nxt       = clr_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    case (state_r)
      aorp_pkg::S_IDLE: begin
        if (accept) begin
          addr_nxt = in_data.index[AW-1:0];
          set_nxt  = in_data.set_mask;
          clr_nxt  = in_data.clear_mask;
          out_data_nxt        = '0;
          out_data_nxt.status = status;
          if (status == aorp_pkg::ST_OK) begin
            case (in_data.opcode)
              aorp_pkg::OP_APPEND: begin
                st_ctl.wr_rec         = 1'b1;
                st_waddr              = count_r[AW-1:0];
                count_nxt             = count_r + CW'(1);
                out_data_nxt.position = aorp_pkg::POS_W'(count_r);
              end
              aorp_pkg::OP_WRITE: st_ctl.wr_rec = 1'b1;
              aorp_pkg::OP_READ, aorp_pkg::OP_SET_FLAGS: st_ctl.rd = 1'b1;
              default: st_ctl = '0;
            endcase
          end
          // A successful read posts its result once the store data returns.
          out_valid_nxt = !(status == aorp_pkg::ST_OK && in_data.opcode == aorp_pkg::OP_READ);
        end
      end
      aorp_pkg::S_READ: begin
        out_valid_nxt                 = 1'b1;
        out_data_nxt                  = '0;
        out_data_nxt.status           = aorp_pkg::ST_OK;
        out_data_nxt.read_key         = st_rdata.kf[aorp_pkg::KEY_BITS-1:0];
        out_data_nxt.read_flags       = st_rdata.kf[aorp_pkg::KF_W-1:aorp_pkg::KEY_BITS];
        out_data_nxt.read_page_number = st_rdata.hint[31:0];
        out_data_nxt.read_epoch       = st_rdata.hint[47:32];
        out_data_nxt.read_slot        = st_rdata.hint[63:48];
        out_data_nxt.read_payload     = st_rdata.pay;
        out_data_nxt.read_group       = st_rdata.grp;
      end
      aorp_pkg::S_MODIFY: begin
        st_ctl.wr_kf = 1'b1;
        st_waddr     = addr_r;
        st_wdata.kf  = {mod_flags, st_rdata.kf[aorp_pkg::KEY_BITS-1:0]};
      end
      default: st_ctl = '0;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= aorp_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    addr_r     <= addr_nxt;
    set_r      <= set_nxt;
    clr_r      <= clr_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The count never passes the capacity.
  `AORP_ASSERT(a_count_bound, clk, rst_n, count_r <= CW'(CAPACITY))
  // The count moves by at most one per cycle, and only upward.
  `AORP_ASSERT_NXT(a_count_step, clk, rst_n, 1'b1, CW'(count_r - $past(count_r)) <= CW'(1))
  // A flag write-back follows an accepted request directly.
  `AORP_ASSERT_IMP(a_modify_origin, clk, rst_n, state_r == aorp_pkg::S_MODIFY, $past(accept))
  // No new request while a store access is still open.
  `AORP_ASSERT_IMP(a_interlock, clk, rst_n, state_r != aorp_pkg::S_IDLE, in_stall)
  // A read and a store write (record or flags) never share a cycle.
  `AORP_ASSERT(a_port_excl, clk, rst_n, !(st_ctl.rd && (st_ctl.wr_rec || st_ctl.wr_kf)))

endmodule

/* sv/append_only_record_page_core.sv */
`timescale 1ns / 1ps
// Channel  Direction  Handshake          Payload
// in_      input      in_valid/in_stall  aorp_pkg::in_req_t
// out_     output     out_valid/out_stall aorp_pkg::out_res_t
//
// Append, write, set-flags and rejected requests post a registered result at
// accept; a successful read posts its result from S_READ with the store data.
// Set-flags writes the updated flag byte back in S_MODIFY, after the store read.
// Reset clears count, state and out_valid; stores are undefined until written.
// A result waiting under out_stall holds the input stalled until it is taken.

module append_only_record_page_core #(
  parameter int CAPACITY = aorp_pkg::CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  aorp_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output aorp_pkg::out_res_t out_data
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  aorp_pkg::store_ctl_t st_ctl;
  logic [AW-1:0]        st_waddr;
  logic [AW-1:0]        st_raddr;
  aorp_pkg::record_t    st_wdata;
  aorp_pkg::record_t    st_rdata;

  // Request sequencing, count and result register.
  aorp_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .st_ctl    (st_ctl),
    .st_waddr  (st_waddr),
    .st_wdata  (st_wdata),
    .st_raddr  (st_raddr),
    .st_rdata  (st_rdata)
  );

  // Record stores.
  aorp_store #(
    .CAPACITY (CAPACITY)
  ) u_store (
    .clk   (clk),
    .ctl   (st_ctl),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

endmodule

/* sim/tb_append_only_record_page_core.sv */
`timescale 1ns / 1ps

module tb_append_only_record_page_core;
  import aorp_pkg::*;

  localparam int PAGE_CAP    = CAPACITY_DEF;
  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 300;
  localparam int BURST_ITEMS = 40;
  localparam int RANDOM_ITEMS = 1680;

  // Predicts every result of the record page and checks results in order.
  class record_page_scoreboard;
    int unsigned count = 0;
    int unsigned errors = 0;
    int unsigned results_seen = 0;
    logic [39:0] rec_key     [PAGE_CAP];
    logic [7:0]  rec_flags   [PAGE_CAP];
    logic [31:0] rec_page    [PAGE_CAP];
    logic [15:0] rec_epoch   [PAGE_CAP];
    logic [15:0] rec_slot    [PAGE_CAP];
    logic [63:0] rec_payload [PAGE_CAP];
    logic [31:0] rec_group   [PAGE_CAP];
    out_res_t expected_q[$];

    function int pending();
      return expected_q.size();
    endfunction

    task report(string msg);
      $display("MISMATCH result %0d: %s", results_seen, msg);
      errors++;
    endtask

    // Stores a record unless its key is wider than 40 bits.
    function status_t store_record(int unsigned at, in_req_t r);
      if (r.key[63:40] != '0) return ST_BAD_ARG;
      rec_key[at]     = r.key[39:0];
      rec_flags[at]   = r.flag_bits;
      rec_page[at]    = r.page_number;
      rec_epoch[at]   = r.epoch;
      rec_slot[at]    = r.slot_hint;
      rec_payload[at] = r.payload;
      rec_group[at]   = r.group;
      return ST_OK;
    endfunction

    // Applies an accepted request to the predicted page and queues its result.
    function void note_request(in_req_t r);
      out_res_t want;
      int unsigned idx;
      want = '0;
      want.status = ST_OK;
      idx = r.index;
      case (r.opcode)
        OP_APPEND: begin
          if (count >= PAGE_CAP) begin
            want.status = ST_NO_SPACE;
          end else begin
            want.status = store_record(count, r);
            if (want.status == ST_OK) begin
              want.position = count[6:0];
              count++;
            end
          end
        end
        OP_READ: begin
          if (idx >= count || idx >= PAGE_CAP) begin
            want.status = ST_RANGE;
          end else begin
            want.read_key         = rec_key[idx];
            want.read_flags       = rec_flags[idx];
            want.read_page_number = rec_page[idx];
            want.read_epoch       = rec_epoch[idx];
            want.read_slot        = rec_slot[idx];
            want.read_payload     = rec_payload[idx];
            want.read_group       = rec_group[idx];
          end
        end
        OP_WRITE: begin
          // The range check comes before the key check.
          if (idx > count || idx >= PAGE_CAP) want.status = ST_RANGE;
          else want.status = store_record(idx, r);
        end
        default: begin
          if (idx >= count || idx >= PAGE_CAP) want.status = ST_RANGE;
          else rec_flags[idx] = (rec_flags[idx] | r.set_mask) & ~r.clear_mask;
        end
      endcase
      expected_q.push_back(want);
    endfunction

    task compare_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want) report($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    // Compares one accepted result with the oldest prediction.
    task check_result(out_res_t got);
      out_res_t want;
      if (expected_q.size() == 0) begin
        report("result arrived with no request outstanding");
      end else begin
        want = expected_q.pop_front();
        compare_field("status", got.status, want.status);
        compare_field("position", got.position, want.position);
        compare_field("read_key", got.read_key, want.read_key);
        compare_field("read_flags", got.read_flags, want.read_flags);
        compare_field("read_page_number", got.read_page_number, want.read_page_number);
        compare_field("read_epoch", got.read_epoch, want.read_epoch);
        compare_field("read_slot", got.read_slot, want.read_slot);
        compare_field("read_payload", got.read_payload, want.read_payload);
        compare_field("read_group", got.read_group, want.read_group);
      end
      results_seen++;
    endtask
  endclass

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  in_req_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  out_res_t out_data;

  bit hold_off = 1'b0;
  int unsigned cycles = 0;
  record_page_scoreboard sb;

  append_only_record_page_core #(
    .CAPACITY(PAGE_CAP)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always #10 clk = ~clk;

  // Run limit.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Both handshakes are observed at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_request(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
    end
  end

  // Result side: short and long stalls, quiet stretches, and one long hold-off.
  initial begin : result_receiver
    int stall_left;
    int quiet_left;
    int pick;
    stall_left = 0;
    quiet_left = 0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        hold_off = 1'b0;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && quiet_left > 0) begin
        quiet_left--;
      end else if (stall_left == 0) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) stall_left = $urandom_range(1, 3);
        else if (pick < 9) stall_left = $urandom_range(10, 40);
        else if (pick < 10) quiet_left = $urandom_range(30, 100);
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic int pick_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 65) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offers one request and returns at the falling edge after it is taken.
  task automatic send_request(input in_req_t r);
    in_data  <= r;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic idle_sender(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // Stops sending until every predicted result has been taken.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic in_req_t directed(op_t op, logic [15:0] idx, logic [63:0] key,
                                       logic [7:0] fill, logic [63:0] pay);
    in_req_t r;
    r.opcode      = op;
    r.index       = idx;
    r.key         = key;
    r.flag_bits   = fill;
    r.page_number = {4{fill}};
    r.epoch       = {2{fill}};
    r.slot_hint   = {2{~fill}};
    r.payload     = pay;
    r.group       = {4{~fill}};
    r.set_mask    = fill;
    r.clear_mask  = ~fill;
    return r;
  endfunction

  // Random request, aimed mostly at positions the page currently holds.
  function automatic in_req_t random_request();
    in_req_t r;
    int pick;
    int unsigned n;
    n = sb.count;
    pick = $urandom_range(0, 99);
    if (pick < 15) r.opcode = OP_APPEND;
    else if (pick < 50) r.opcode = OP_READ;
    else if (pick < 75) r.opcode = OP_WRITE;
    else r.opcode = OP_SET_FLAGS;
    pick = $urandom_range(0, 99);
    if (pick < 75) r.index = (n == 0) ? 16'd0 : 16'($urandom_range(0, n - 1));
    else if (pick < 85) r.index = 16'(n);
    else if (pick < 90) r.index = 16'(n + 1);
    else if (pick < 95) r.index = 16'(PAGE_CAP - 1 + $urandom_range(0, 1));
    else r.index = 16'($urandom);
    r.key = {$urandom, $urandom};
    pick = $urandom_range(0, 99);
    if (pick < 85) begin
      r.key[63:40] = '0;
    end else if (pick < 88) begin
      r.key = 64'h1 << 40;
    end else if (r.key[63:40] == '0) begin
      r.key[40 + $urandom_range(0, 23)] = 1'b1;
    end
    r.flag_bits   = 8'($urandom);
    r.page_number = $urandom;
    r.epoch       = 16'($urandom);
    r.slot_hint   = 16'($urandom);
    r.payload     = {$urandom, $urandom};
    r.group       = $urandom;
    r.set_mask    = 8'($urandom);
    r.clear_mask  = 8'($urandom);
    return r;
  endfunction

  // Edge cases on an empty page, then on a two-record page.
  task automatic run_directed();
    in_req_t r [$];
    in_req_t q;
    r.push_back(directed(OP_READ, 16'd0, 64'd0, 8'h00, 64'd0));
    r.push_back(directed(OP_SET_FLAGS, 16'd0, 64'd0, 8'h00, 64'd0));
    r.push_back(directed(OP_WRITE, 16'd0, 64'h12_3456_789A, 8'hA5, 64'd1));
    r.push_back(directed(OP_APPEND, 16'd0, 64'h1 << 40, 8'hFF, 64'd0));
    r.push_back(directed(OP_APPEND, 16'd0, (64'h1 << 40) - 1, 8'hFF, 64'h8000_0000_0000_0000));
    r.push_back(directed(OP_APPEND, 16'hFFFF, 64'd0, 8'h00, 64'h7FFF_FFFF_FFFF_FFFF));
    r.push_back(directed(OP_READ, 16'd0, 64'd0, 8'h00, 64'd0));
    r.push_back(directed(OP_READ, 16'd1, 64'd0, 8'h00, 64'd0));
    r.push_back(directed(OP_READ, 16'd2, 64'd0, 8'h00, 64'd0));
    r.push_back(directed(OP_READ, 16'hFFFF, 64'd0, 8'h00, 64'd0));
    r.push_back(directed(OP_WRITE, 16'd2, '1, 8'h3C, 64'd5));
    r.push_back(directed(OP_WRITE, 16'd3, '1, 8'h3C, 64'd5));
    r.push_back(directed(OP_WRITE, 16'd1, 64'hAB_CDEF_0123, 8'h5A, -64'sd2));
    r.push_back(directed(OP_READ, 16'd1, 64'd0, 8'h00, 64'd0));
    q = directed(OP_SET_FLAGS, 16'd0, 64'd0, 8'h00, 64'd0);
    q.set_mask = 8'hFF;
    q.clear_mask = 8'h55;
    r.push_back(q);
    r.push_back(directed(OP_READ, 16'd0, 64'd0, 8'h00, 64'd0));
    q = directed(OP_SET_FLAGS, 16'd1, 64'd0, 8'h00, 64'd0);
    q.set_mask = 8'h0F;
    q.clear_mask = 8'h00;
    r.push_back(q);
    r.push_back(directed(OP_READ, 16'd1, 64'd0, 8'h00, 64'd0));
    r.push_back(directed(OP_SET_FLAGS, 16'hFFFF, 64'd0, 8'hFF, 64'd0));
    r.push_back(directed(OP_WRITE, 16'hFFFF, 64'd7, 8'hFF, 64'd0));
    r.push_back(directed(OP_APPEND, 16'd0, '1, 8'hFF, '1));
    foreach (r[i]) begin
      send_request(r[i]);
      idle_sender(pick_gap());
    end
  endtask

  initial begin
    sb = new();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    run_directed();
    wait_drained();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 600) begin
        // Long hold-off on the result side while requests keep coming back to back.
        hold_off = 1'b1;
        repeat (BURST_ITEMS) send_request(random_request());
      end
      if (i == 1200) wait_drained();
      send_request(random_request());
      if (i % 300 < 40) idle_sender(0);
      else idle_sender(pick_gap());
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+sv
sv/aorp_pkg.sv
sv/aorp_store.sv
sv/aorp_ctrl.sv
sv/append_only_record_page_core.sv
sim/tb_append_only_record_page_core.sv
